>>> src/mf2d_pkg.sv
`default_nettype none
package mf2d_pkg;

   localparam int PIX_W = 8;
   localparam int HIST_BINS = 256;
   localparam int BIN_W = 9;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd2;

   localparam logic [10:0] RESET_IMAGE_WIDTH = 11'd640;
   localparam logic [12:0] RESET_IMAGE_HEIGHT = 13'd480;
   localparam logic [3:0] RESET_WINDOW_SIZE = 4'd3;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_LS_RD,
      ST_H_RD,
      ST_H_WR,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic clear;
      logic win_init;
      logic h_wr;
      logic scan_init;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_ready;
      logic win_last;
      logic clear_done;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> src/mf2d_ram.sv
`default_nettype none
module mf2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> src/mf2d_ctrl.sv
`default_nettype none
module mf2d_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire mf2d_pkg::sts_type sts,
   output mf2d_pkg::cmd_type      cmd
);

   mf2d_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mf2d_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         mf2d_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = mf2d_pkg::ST_IDLE;
            end
         end
         mf2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = mf2d_pkg::ST_CHECK;
            end
         end
         mf2d_pkg::ST_CHECK: begin
            if (sts.out_ready) begin
               cmd.win_init = 1'b1;
               state_in = mf2d_pkg::ST_LS_RD;
            end else begin
               state_in = mf2d_pkg::ST_IDLE;
            end
         end
         mf2d_pkg::ST_LS_RD: begin
            state_in = mf2d_pkg::ST_H_RD;
         end
         mf2d_pkg::ST_H_RD: begin
            state_in = mf2d_pkg::ST_H_WR;
         end
         mf2d_pkg::ST_H_WR: begin
            cmd.h_wr = 1'b1;
            if (sts.win_last) begin
               cmd.scan_init = 1'b1;
               state_in = mf2d_pkg::ST_SCAN;
            end else begin
               state_in = mf2d_pkg::ST_LS_RD;
            end
         end
         mf2d_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = mf2d_pkg::ST_EMIT;
            end
         end
         mf2d_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = mf2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mf2d_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> src/mf2d_dp.sv
`default_nettype none
module mf2d_dp #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 7
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [mf2d_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [mf2d_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic                                   in_action,
   input  wire logic [mf2d_pkg::PIX_W-1:0]             in_pixel,
   input  wire logic                                   rsp_tready,
   output logic                                        rsp_tvalid,
   output logic [mf2d_pkg::PIX_W-1:0]                  rsp_median,
   output logic                                        rsp_last,
   input  wire mf2d_pkg::cmd_type                      cmd,
   output mf2d_pkg::sts_type                           sts
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int LS_ROWS = 3 * MAX_RADIUS + 2;
   localparam int SLOT_W = $clog2(LS_ROWS);
   localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
   localparam int ADDR_W = $clog2(LS_DEPTH);
   localparam int RAD_W = $clog2(MAX_RADIUS + 1);
   localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
   localparam int HAW = $clog2(mf2d_pkg::HIST_BINS);

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [3:0]  wsize_ff;

   logic [COL_W-1:0]  in_col_ff, out_col_ff;
   logic [ROW_W-1:0]  in_row_ff, out_row_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff;
   logic              ahead_ff;

   logic signed [RAD_W:0] dy_ff, dx_ff;
   logic [mf2d_pkg::BIN_W-1:0] bin_ff;
   logic [CNT_W-1:0] acc_ff;
   logic             found_ff;
   logic [mf2d_pkg::PIX_W-1:0] median_ff;

   logic                       rsp_valid_ff;
   logic [mf2d_pkg::PIX_W-1:0] rsp_median_ff;
   logic                       rsp_last_ff;

   logic [COL_W-1:0] wm1;
   logic [ROW_W-1:0] hm1;
   logic [RAD_W-1:0] rad;
   logic signed [RAD_W:0] rad_s;

   always_comb begin
      if (width_ff == 11'd0) begin
         wm1 = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(width_ff - 11'd1);
      end
      if (height_ff == 13'd0) begin
         hm1 = '0;
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         hm1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hm1 = ROW_W'(height_ff - 13'd1);
      end
      if (int'(wsize_ff[3:1]) > MAX_RADIUS) begin
         rad = RAD_W'(MAX_RADIUS);
      end else begin
         rad = RAD_W'(wsize_ff[3:1]);
      end
      rad_s = $signed({1'b0, rad});
   end

   logic [CNT_W-1:0] side, target;
   always_comb begin
      side = CNT_W'({rad, 1'b1});
      target = CNT_W'((side * side) >> 1);
   end

   logic [ROW_W:0] need_row_w;
   logic [COL_W:0] need_col_w;
   logic [ROW_W-1:0] need_row;
   logic [COL_W-1:0] need_col;
   logic out_ready;
   always_comb begin
      need_row_w = {1'b0, out_row_ff} + (ROW_W + 1)'(rad);
      need_col_w = {1'b0, out_col_ff} + (COL_W + 1)'(rad);
      need_row = (need_row_w > {1'b0, hm1}) ? hm1 : need_row_w[ROW_W-1:0];
      need_col = (need_col_w > {1'b0, wm1}) ? wm1 : need_col_w[COL_W-1:0];
      out_ready = ahead_ff || (in_row_ff > need_row)
         || (in_row_ff == need_row && in_col_ff > need_col);
   end

   logic signed [ROW_W+1:0] row_s, off_s;
   logic signed [COL_W+1:0] col_s;
   logic [ROW_W-1:0] row_cl;
   logic [COL_W-1:0] col_cl;
   logic signed [SLOT_W+1:0] slot_s;
   logic [SLOT_W-1:0] rd_slot;
   logic [ADDR_W-1:0] ls_raddr, ls_waddr;
   logic [COL_W-1:0] wr_col;

   always_comb begin
      row_s = $signed({2'b00, out_row_ff}) + (ROW_W + 2)'(dy_ff);
      if (row_s < 0) begin
         row_cl = '0;
      end else if (row_s > $signed({2'b00, hm1})) begin
         row_cl = hm1;
      end else begin
         row_cl = row_s[ROW_W-1:0];
      end
      col_s = $signed({2'b00, out_col_ff}) + (COL_W + 2)'(dx_ff);
      if (col_s < 0) begin
         col_cl = '0;
      end else if (col_s > $signed({2'b00, wm1})) begin
         col_cl = wm1;
      end else begin
         col_cl = col_s[COL_W-1:0];
      end
      off_s = $signed({2'b00, row_cl}) - $signed({2'b00, out_row_ff});
      slot_s = $signed({2'b00, out_slot_ff}) + (SLOT_W + 2)'(off_s);
      if (slot_s < 0) begin
         slot_s = slot_s + (SLOT_W + 2)'(LS_ROWS);
      end else if (slot_s >= $signed((SLOT_W + 2)'(LS_ROWS))) begin
         slot_s = slot_s - (SLOT_W + 2)'(LS_ROWS);
      end
      rd_slot = slot_s[SLOT_W-1:0];
      ls_raddr = ADDR_W'(int'(rd_slot) * MAX_WIDTH + int'(col_cl));
      wr_col = (in_col_ff > wm1) ? wm1 : in_col_ff;
      ls_waddr = ADDR_W'(int'(in_slot_ff) * MAX_WIDTH + int'(wr_col));
   end

   logic ls_we;
   logic [mf2d_pkg::PIX_W-1:0] ls_rdata;
   assign ls_we = cmd.take && (in_action == mf2d_pkg::ACT_PUSH);

   mf2d_ram #(
      .WIDTH(mf2d_pkg::PIX_W),
      .DEPTH(LS_DEPTH)
   ) u_line_store (
      .clock(clock),
      .we(ls_we),
      .waddr(ls_waddr),
      .wdata(in_pixel),
      .raddr(ls_raddr),
      .rdata(ls_rdata)
   );

   logic           h_we;
   logic [HAW-1:0] h_waddr, h_raddr;
   logic [CNT_W-1:0] h_wdata, h_rdata;
   logic [mf2d_pkg::BIN_W-1:0] bin_prev;

   always_comb begin
      bin_prev = bin_ff - mf2d_pkg::BIN_W'(1);
      h_raddr = cmd.scan ? bin_ff[HAW-1:0] : ls_rdata;
      h_we = 1'b0;
      h_waddr = ls_rdata;
      h_wdata = '0;
      if (cmd.clear) begin
         h_we = 1'b1;
         h_waddr = bin_ff[HAW-1:0];
      end else if (cmd.scan) begin
         h_we = (bin_ff != '0);
         h_waddr = bin_prev[HAW-1:0];
      end else if (cmd.h_wr) begin
         h_we = 1'b1;
         h_wdata = h_rdata + CNT_W'(1);
      end
   end

   mf2d_ram #(
      .WIDTH(CNT_W),
      .DEPTH(mf2d_pkg::HIST_BINS)
   ) u_histogram (
      .clock(clock),
      .we(h_we),
      .waddr(h_waddr),
      .wdata(h_wdata),
      .raddr(h_raddr),
      .rdata(h_rdata)
   );

   logic [CNT_W-1:0] acc_sum;
   assign acc_sum = acc_ff + h_rdata;

   assign sts.out_ready = out_ready;
   assign sts.win_last = (dx_ff == rad_s) && (dy_ff == rad_s);
   assign sts.clear_done = (bin_ff == mf2d_pkg::BIN_W'(mf2d_pkg::HIST_BINS - 1));
   assign sts.scan_done = (bin_ff == mf2d_pkg::BIN_W'(mf2d_pkg::HIST_BINS));
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= mf2d_pkg::RESET_IMAGE_WIDTH;
         height_ff <= mf2d_pkg::RESET_IMAGE_HEIGHT;
         wsize_ff <= mf2d_pkg::RESET_WINDOW_SIZE;
      end else if (csr_we) begin
         case (csr_index)
            mf2d_pkg::CSR_IMAGE_WIDTH: width_ff <= csr_wdata[10:0];
            mf2d_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            mf2d_pkg::CSR_WINDOW_SIZE: wsize_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_slot_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_slot_ff <= '0;
         ahead_ff <= 1'b0;
         bin_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ls_we) begin
            if (in_col_ff >= wm1) begin
               in_col_ff <= '0;
               in_slot_ff <= (int'(in_slot_ff) == LS_ROWS - 1) ? '0
                  : in_slot_ff + SLOT_W'(1);
               if (in_row_ff >= hm1) begin
                  in_row_ff <= '0;
                  ahead_ff <= 1'b1;
               end else begin
                  in_row_ff <= in_row_ff + ROW_W'(1);
               end
            end else begin
               in_col_ff <= in_col_ff + COL_W'(1);
            end
         end
         if (cmd.emit) begin
            if (out_col_ff >= wm1) begin
               out_col_ff <= '0;
               out_slot_ff <= (int'(out_slot_ff) == LS_ROWS - 1) ? '0
                  : out_slot_ff + SLOT_W'(1);
               if (out_row_ff >= hm1) begin
                  out_row_ff <= '0;
                  ahead_ff <= 1'b0;
               end else begin
                  out_row_ff <= out_row_ff + ROW_W'(1);
               end
            end else begin
               out_col_ff <= out_col_ff + COL_W'(1);
            end
         end
         if (cmd.scan_init) begin
            bin_ff <= '0;
         end else if ((cmd.clear || cmd.scan) && !sts.scan_done) begin
            bin_ff <= bin_ff + mf2d_pkg::BIN_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_init) begin
         dy_ff <= -rad_s;
         dx_ff <= -rad_s;
      end else if (cmd.h_wr) begin
         if (dx_ff == rad_s) begin
            dx_ff <= -rad_s;
            dy_ff <= dy_ff + (RAD_W + 1)'(1);
         end else begin
            dx_ff <= dx_ff + (RAD_W + 1)'(1);
         end
      end
      if (cmd.scan_init) begin
         acc_ff <= '0;
         found_ff <= 1'b0;
         median_ff <= '1;
      end else if (cmd.scan && bin_ff != '0) begin
         acc_ff <= acc_sum;
         if (!found_ff && acc_sum > target) begin
            found_ff <= 1'b1;
            median_ff <= bin_prev[mf2d_pkg::PIX_W-1:0];
         end
      end
      if (cmd.emit) begin
         rsp_median_ff <= median_ff;
         rsp_last_ff <= (out_row_ff >= hm1) && (out_col_ff >= wm1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_last = rsp_last_ff;

endmodule
`default_nettype wire

>>> src/median_filter_2d.sv
// An item that yields no result passes through the idle and check states only; an item that yields a result
// is processed by one line-store read and one histogram read-modify-write per window pixel, followed by a
// 256-bin histogram scan, and then waits in the emit state until the output register is free.
// Results leave through an output register, so the next transaction is taken while one waits.
// After reset the block zeroes the histogram memory before taking input;
// the line store is not cleared.
`default_nettype none
module median_filter_2d #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 7
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [mf2d_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mf2d_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // pixel
   input  wire logic                              req_tuser,  // action
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata,  // median
   output logic                                   rsp_tlast
);

   mf2d_pkg::cmd_type cmd;
   mf2d_pkg::sts_type sts;

   mf2d_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts(sts),
      .cmd(cmd)
   );

   mf2d_dp #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RADIUS(MAX_RADIUS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_action(req_tuser),
      .in_pixel(req_tdata),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_median(rsp_tdata),
      .rsp_last(rsp_tlast),
      .cmd(cmd),
      .sts(sts)
   );

endmodule
`default_nettype wire
